/* hdl/acds_pkg.sv */
// package: shared types, widths and constants of the aged channel delta scheduler
`timescale 1ns / 1ps
`default_nettype none
package acds_pkg;

  // default sizes
  localparam int UniverseSizeDef   = 512;
  localparam int NumLightsDef      = 85;
  localparam int LightChannelsDef  = 6;
  localparam int MaxPacketBytesDef = 64;

  // field widths
  localparam int ReqW    = 2;
  localparam int ChanW   = 9;
  localparam int ValW    = 8;
  localparam int BudgetW = 7;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 8;

  // age marks
  localparam logic [7:0] AgeChanged = 8'd255;
  localparam logic [7:0] AgeResync  = 8'd128;
  localparam logic [7:0] RepeatRst  = 8'd3;

  typedef enum logic [ReqW-1:0] {
    REQ_SET    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_RESYNC = 2'd2,
    REQ_GEN    = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REPEAT  = 1'b0,
    CFG_REFRESH = 1'b1
  } cfg_idx_e;

endpackage
`default_nettype wire

/* hdl/acds_if.sv */
// interfaces: request and result channels
`timescale 1ns / 1ps
`default_nettype none
interface acds_in_if;
  logic                          valid;
  logic                          ready;
  logic [acds_pkg::ReqW-1:0]     req_type;
  logic [acds_pkg::ChanW-1:0]    channel;
  logic [acds_pkg::ValW-1:0]     value;
  logic [acds_pkg::BudgetW-1:0]  max_bytes;
  modport source (output valid, req_type, channel, value, max_bytes, input ready);
  modport sink (input valid, req_type, channel, value, max_bytes, output ready);
endinterface

interface acds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       byte_valid;
  logic       last;
  logic [7:0] read_value;
  modport source (output valid, cmd_byte, byte_valid, last, read_value, input ready);
  modport sink (input valid, cmd_byte, byte_valid, last, read_value, output ready);
endinterface
`default_nettype wire

/* hdl/acds_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module acds_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/aged_channel_delta_scheduler_core.sv */
// top level: channel table, age scheduler sequencer and packet buffer
//
// The block holds a pending value, a current value and an age for each of
// UniverseSize channels in two rams (pending; current and age side by side),
// and builds packets of light commands in a small packet ram. Everything runs
// through one sequencer that walks the rams one entry at a time with a single
// compare/increment unit, so the request port is ready only while the
// sequencer idles. After reset a clearing pass writes zero to every table
// entry before the first request is taken. A set request writes the
// pending table, a read returns the pending value, and a resync copies
// every pending value into the current table with the resync age. A
// generate request runs the change mark sweep, then passes of the
// highest-age scan and the light walk that emits packet bytes, the age
// refresh when enabled, and hands the packet bytes to the result side one
// by one, waiting while the sink stalls. Results sit in an output register,
// and the sequencer only waits on it when it has the next result to hand over.
`timescale 1ns / 1ps
`default_nettype none
module aged_channel_delta_scheduler_core #(
  parameter int UniverseSize   = acds_pkg::UniverseSizeDef,
  parameter int NumLights      = acds_pkg::NumLightsDef,
  parameter int LightChannels  = acds_pkg::LightChannelsDef,
  parameter int MaxPacketBytes = acds_pkg::MaxPacketBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  acds_in_if.sink                            req_i,
  acds_out_if.source                         res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [acds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [acds_pkg::CfgW-1:0]     cfg_wdata_i
);
  localparam int AW   = $clog2(UniverseSize);
  localparam int CHW  = $clog2(NumLights * LightChannels + UniverseSize);
  localparam int LW   = (NumLights > 1) ? $clog2(NumLights) : 1;
  localparam int KW   = $clog2(LightChannels + 1);
  localparam int KIW  = $clog2(LightChannels);
  localparam int PAW  = $clog2(MaxPacketBytes);
  localparam int PLW0 = $clog2(MaxPacketBytes + 1);
  localparam int PLW  = (PLW0 < 3) ? 3 : PLW0;

  // one-hot sequencer states
  typedef enum logic [20:0] {
    ST_CLR    = 21'h000001,
    ST_IDLE   = 21'h000002,
    ST_RDW    = 21'h000004,
    ST_ACK    = 21'h000008,
    ST_SW_RD  = 21'h000010,
    ST_SW_WR  = 21'h000020,
    ST_SC_RD  = 21'h000040,
    ST_SC_CMP = 21'h000080,
    ST_SC_END = 21'h000100,
    ST_L_RD   = 21'h000200,
    ST_L_CAP  = 21'h000400,
    ST_L_DEC  = 21'h000800,
    ST_C_CHK  = 21'h001000,
    ST_EMIT   = 21'h002000,
    ST_L_END  = 21'h004000,
    ST_G_CHK  = 21'h008000,
    ST_RF_RD  = 21'h010000,
    ST_RF_WR  = 21'h020000,
    ST_O_CHK  = 21'h040000,
    ST_O_RD   = 21'h080000,
    ST_O_LD   = 21'h100000
  } state_e;

  typedef enum logic [1:0] {
    K_HSB = 2'd0,
    K_BRI = 2'd1,
    K_IDX = 2'd2
  } kind_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  acds_pkg::req_e req_q, req_d;

  logic [7:0]     irc_q;
  logic           rfr_q;
  logic [8:0]     ch_q, ch_d;
  logic [AW-1:0]  i_q, i_d;
  logic [PLW-1:0] room_q, room_d;
  logic [8:0]     ceil_q, ceil_d;
  logic [7:0]     pass_q, pass_d;
  logic [7:0]     done_q, done_d;
  logic [LW-1:0]  lidx_q, lidx_d;
  logic [CHW-1:0] base_q, base_d;
  logic [7:0]     cmd_q, cmd_d;
  logic [KW-1:0]  k_q, k_d;
  logic [1:0]     e_q, e_d;
  logic [PLW-1:0] plen_q, plen_d;
  logic [PAW-1:0] o_q, o_d;
  logic [7:0]     bage_q [LightChannels];
  logic [7:0]     bage_d [LightChannels];
  logic [7:0]     bcur_q [LightChannels];
  logic [7:0]     bcur_d [LightChannels];

  // output register
  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       obv_q, obv_d;
  logic       ol_q, ol_d;
  logic [7:0] orv_q, orv_d;

  // ram ports
  logic          pend_we;
  logic [AW-1:0] pend_waddr, pend_raddr;
  logic [7:0]    pend_wdata, pend_rdata;
  logic          ca_we;
  logic [AW-1:0] ca_waddr, ca_raddr;
  logic [15:0]   ca_wdata, ca_rdata;
  logic           pk_we;
  logic [PAW-1:0] pk_waddr;
  logic [7:0]     pk_wdata, pk_rdata;

  acds_ram #(.Width(8), .Depth(UniverseSize)) u_pend (
    .clk_i, .we_i(pend_we), .waddr_i(pend_waddr), .wdata_i(pend_wdata),
    .raddr_i(pend_raddr), .rdata_o(pend_rdata)
  );
  acds_ram #(.Width(16), .Depth(UniverseSize)) u_ca (
    .clk_i, .we_i(ca_we), .waddr_i(ca_waddr), .wdata_i(ca_wdata),
    .raddr_i(ca_raddr), .rdata_o(ca_rdata)
  );
  acds_ram #(.Width(8), .Depth(MaxPacketBytes)) u_pkt (
    .clk_i, .we_i(pk_we), .waddr_i(pk_waddr), .wdata_i(pk_wdata),
    .raddr_i(o_q), .rdata_o(pk_rdata)
  );

  // shared datapath terms
  logic [7:0]     thresh;
  logic [7:0]     ca_cur, ca_age;
  logic           out_free, last_i, ch_inr, in_inr;
  logic [CHW-1:0] chaddr;
  logic           chaddr_inr;
  logic [7:0]     cur_k, age_k, ebyte;
  logic           edata, elast;
  logic [PLW-1:0] elen;
  logic [6:0]     budget_sat;

  assign thresh     = 8'd255 - irc_q;
  assign ca_cur     = ca_rdata[15:8];
  assign ca_age     = ca_rdata[7:0];
  assign out_free   = !ov_q || res_o.ready;
  assign last_i     = (i_q == AW'(UniverseSize - 1));
  assign ch_inr     = ({1'b0, ch_q} < 10'(UniverseSize));
  assign in_inr     = ({1'b0, req_i.channel} < 10'(UniverseSize));
  assign chaddr     = base_q + CHW'(k_q);
  assign chaddr_inr = (chaddr < CHW'(UniverseSize));
  assign cur_k      = bcur_q[k_q[KIW-1:0]];
  assign age_k      = bage_q[k_q[KIW-1:0]];
  assign budget_sat = (req_i.max_bytes > 7'(MaxPacketBytes)) ? 7'(MaxPacketBytes)
                                                             : req_i.max_bytes;
  assign req_i.ready = (state_q == ST_IDLE);

  // command byte former for the current emit step
  always_comb begin
    ebyte = cur_k;
    edata = 1'b0;
    elast = 1'b0;
    elen  = PLW'(2);
    case (kind_q)
      K_HSB: begin
        if (e_q == 2'd0) ebyte = cmd_q + 8'd1;
        edata = (e_q != 2'd0);
        elast = (e_q == 2'd3);
        elen  = PLW'(4);
      end
      K_BRI: begin
        if (e_q == 2'd0) ebyte = cmd_q;
        edata = (e_q == 2'd1);
        elast = (e_q == 2'd1);
        elen  = PLW'(2);
      end
      K_IDX: begin
        if (e_q == 2'd0) ebyte = cmd_q + 8'd2;
        else if (e_q == 2'd1) ebyte = 8'(k_q);
        edata = (e_q == 2'd2);
        elast = (e_q == 2'd2);
        elen  = PLW'(3);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    req_d   = req_q;
    ch_d    = ch_q;
    i_d     = i_q;
    room_d  = room_q;
    ceil_d  = ceil_q;
    pass_d  = pass_q;
    done_d  = done_q;
    lidx_d  = lidx_q;
    base_d  = base_q;
    cmd_d   = cmd_q;
    k_d     = k_q;
    e_d     = e_q;
    plen_d  = plen_q;
    o_d     = o_q;
    bage_d  = bage_q;
    bcur_d  = bcur_q;
    ov_d    = ov_q && !res_o.ready;
    ob_d    = ob_q;
    obv_d   = obv_q;
    ol_d    = ol_q;
    orv_d   = orv_q;

    pend_we    = 1'b0;
    pend_waddr = i_q;
    pend_wdata = 8'd0;
    pend_raddr = i_q;
    ca_we      = 1'b0;
    ca_waddr   = i_q;
    ca_wdata   = 16'd0;
    ca_raddr   = i_q;
    pk_we      = 1'b0;
    pk_waddr   = plen_q[PAW-1:0];
    pk_wdata   = ebyte;

    case (state_q)
      // zero both tables after reset
      ST_CLR: begin
        pend_we = 1'b1;
        ca_we   = 1'b1;
        i_d     = i_q + AW'(1);
        if (last_i) state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          req_d  = acds_pkg::req_e'(req_i.req_type);
          ch_d   = req_i.channel;
          room_d = PLW'(budget_sat);
          i_d    = '0;
          plen_d = '0;
          case (acds_pkg::req_e'(req_i.req_type))
            acds_pkg::REQ_SET: begin
              pend_we    = in_inr;
              pend_waddr = req_i.channel[AW-1:0];
              pend_wdata = req_i.value;
              state_d    = ST_ACK;
            end
            acds_pkg::REQ_READ: state_d = ST_RDW;
            default: state_d = ST_SW_RD;
          endcase
        end
      end

      ST_RDW: begin
        pend_raddr = ch_q[AW-1:0];
        state_d    = ST_ACK;
      end

      // single-result acknowledgment, read answer or empty packet
      ST_ACK: begin
        pend_raddr = ch_q[AW-1:0];
        if (out_free) begin
          ov_d    = 1'b1;
          ob_d    = 8'd0;
          obv_d   = 1'b0;
          ol_d    = 1'b1;
          orv_d   = (req_q == acds_pkg::REQ_READ && ch_inr) ? pend_rdata : 8'd0;
          state_d = ST_IDLE;
        end
      end

      // resync copy or change mark sweep
      ST_SW_RD: state_d = ST_SW_WR;
      ST_SW_WR: begin
        if (req_q == acds_pkg::REQ_RESYNC) begin
          ca_we    = 1'b1;
          ca_wdata = {pend_rdata, acds_pkg::AgeResync};
        end else begin
          ca_we    = (pend_rdata != ca_cur);
          ca_wdata = {pend_rdata, acds_pkg::AgeChanged};
        end
        i_d = i_q + AW'(1);
        if (!last_i) begin
          state_d = ST_SW_RD;
        end else if (req_q == acds_pkg::REQ_RESYNC) begin
          state_d = ST_ACK;
        end else begin
          ceil_d  = 9'd256;
          state_d = ST_G_CHK;
        end
      end

      ST_G_CHK: begin
        i_d    = '0;
        pass_d = 8'd0;
        if (room_q >= PLW'(2)) state_d = ST_SC_RD;
        else state_d = rfr_q ? ST_RF_RD : ST_O_CHK;
      end

      // highest age below the ceiling
      ST_SC_RD: state_d = ST_SC_CMP;
      ST_SC_CMP: begin
        if (ca_age > pass_q && {1'b0, ca_age} < ceil_q) pass_d = ca_age;
        i_d = i_q + AW'(1);
        state_d = last_i ? ST_SC_END : ST_SC_RD;
      end
      ST_SC_END: begin
        i_d = '0;
        if (pass_q == 8'd0) begin
          state_d = rfr_q ? ST_RF_RD : ST_O_CHK;
        end else begin
          if (pass_q > thresh) begin
            ceil_d = {1'b0, thresh};
            done_d = pass_q - 8'd1;
          end else begin
            ceil_d = {1'b0, pass_q};
            done_d = 8'd0;
          end
          lidx_d  = '0;
          base_d  = '0;
          cmd_d   = 8'd0;
          k_d     = '0;
          state_d = ST_L_RD;
        end
      end

      // load one light's channels into the local buffer
      ST_L_RD: begin
        ca_raddr = chaddr[AW-1:0];
        state_d  = ST_L_CAP;
      end
      ST_L_CAP: begin
        bage_d[k_q[KIW-1:0]] = chaddr_inr ? ca_age : 8'd0;
        bcur_d[k_q[KIW-1:0]] = chaddr_inr ? ca_cur : 8'd0;
        if (k_q == KW'(LightChannels - 1)) begin
          k_d     = '0;
          state_d = ST_L_DEC;
        end else begin
          k_d     = k_q + KW'(1);
          state_d = ST_L_RD;
        end
      end

      ST_L_DEC: begin
        e_d = 2'd0;
        if ((bage_q[0] == pass_q || bage_q[1] == pass_q) && room_q >= PLW'(4)) begin
          kind_d  = K_HSB;
          k_d     = '0;
          state_d = ST_EMIT;
        end else if (bage_q[2] == pass_q) begin
          kind_d  = K_BRI;
          k_d     = KW'(2);
          state_d = ST_EMIT;
        end else begin
          k_d     = KW'(3);
          state_d = ST_C_CHK;
        end
      end

      // indexed channels three and up
      ST_C_CHK: begin
        e_d = 2'd0;
        if (k_q == KW'(LightChannels)) begin
          state_d = ST_L_END;
        end else if (age_k == pass_q && room_q >= PLW'(3)) begin
          kind_d  = K_IDX;
          state_d = ST_EMIT;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      // one command byte a cycle; data bytes also retire the channel's age
      ST_EMIT: begin
        pk_we  = 1'b1;
        plen_d = plen_q + PLW'(1);
        e_d    = e_q + 2'd1;
        if (edata) begin
          ca_we    = chaddr_inr;
          ca_waddr = chaddr[AW-1:0];
          ca_wdata = {cur_k, done_q};
          k_d      = (kind_q == K_BRI) ? KW'(3) : k_q + KW'(1);
        end
        if (elast) begin
          room_d  = room_q - elen;
          state_d = ST_C_CHK;
        end
      end

      ST_L_END: begin
        if (room_q < PLW'(2) || lidx_q == LW'(NumLights - 1)) begin
          state_d = ST_G_CHK;
        end else begin
          lidx_d  = lidx_q + LW'(1);
          base_d  = base_q + CHW'(LightChannels);
          cmd_d   = cmd_q + 8'd3;
          k_d     = '0;
          state_d = ST_L_RD;
        end
      end

      // age refresh below the repeat threshold
      ST_RF_RD: state_d = ST_RF_WR;
      ST_RF_WR: begin
        ca_we    = (ca_age < thresh);
        ca_wdata = {ca_cur, ca_age + 8'd1};
        i_d      = i_q + AW'(1);
        state_d  = last_i ? ST_O_CHK : ST_RF_RD;
      end

      ST_O_CHK: begin
        o_d     = '0;
        state_d = (plen_q == '0) ? ST_ACK : ST_O_RD;
      end
      ST_O_RD: state_d = ST_O_LD;
      ST_O_LD: begin
        if (out_free) begin
          ov_d  = 1'b1;
          ob_d  = pk_rdata;
          obv_d = 1'b1;
          ol_d  = (PLW'(o_q) == plen_q - PLW'(1));
          orv_d = 8'd0;
          if (PLW'(o_q) == plen_q - PLW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            o_d     = o_q + PAW'(1);
            state_d = ST_O_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      i_q     <= '0;
      ov_q    <= 1'b0;
      irc_q   <= acds_pkg::RepeatRst;
      rfr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (acds_pkg::cfg_idx_e'(cfg_idx_i))
          acds_pkg::CFG_REPEAT:  irc_q <= cfg_wdata_i;
          acds_pkg::CFG_REFRESH: rfr_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    req_q  <= req_d;
    ch_q   <= ch_d;
    room_q <= room_d;
    ceil_q <= ceil_d;
    pass_q <= pass_d;
    done_q <= done_d;
    lidx_q <= lidx_d;
    base_q <= base_d;
    cmd_q  <= cmd_d;
    k_q    <= k_d;
    e_q    <= e_d;
    plen_q <= plen_d;
    o_q    <= o_d;
    bage_q <= bage_d;
    bcur_q <= bcur_d;
    ob_q   <= ob_d;
    obv_q  <= obv_d;
    ol_q   <= ol_d;
    orv_q  <= orv_d;
  end

  assign res_o.valid      = ov_q;
  assign res_o.cmd_byte   = ob_q;
  assign res_o.byte_valid = obv_q;
  assign res_o.last       = ol_q;
  assign res_o.read_value = orv_q;
endmodule
`default_nettype wire

/* hdl/acds_chk.sv */
// checker: port-level properties of the scheduler and its bind
`timescale 1ns / 1ps
`default_nettype none
module acds_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] cmd_byte_i,
  input wire logic       byte_valid_i,
  input wire logic       last_i,
  input wire logic [7:0] read_value_i
);
  // a request transaction always starts work, so ready drops next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request port ready right after a transaction");

  // a non-byte result is always the single last result
  a_ack_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !byte_valid_i) |-> (last_i && cmd_byte_i == 8'd0))
    else $error("acknowledgment without last or with a byte");

  // read data only rides on an acknowledgment
  a_read_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && read_value_i != 8'd0) |-> (!byte_valid_i && last_i))
    else $error("read value on a packet byte");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(cmd_byte_i)
      && $stable(last_i)))
    else $error("stalled result changed");
endmodule

bind aged_channel_delta_scheduler_core acds_chk u_acds_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .cmd_byte_i   (res_o.cmd_byte),
  .byte_valid_i (res_o.byte_valid),
  .last_i       (res_o.last),
  .read_value_i (res_o.read_value)
);
`default_nettype wire
